### hdl/kmc_pkg.sv
// Package for the keyboard matrix controller: field widths, function and register codes,
// matrix row numbers and bit masks, and the constant joystick derivation table.
// Used by kmc_ram and keyboard_matrix_controller; depends on nothing else.
package kmc_pkg;

    localparam int FUNC_W        = 3;
    localparam int CODE_W        = 9;
    localparam int ROW_W         = 5;
    localparam int BYTE_W        = 8;
    localparam int ENTRY_W       = ROW_W + BYTE_W;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int KEY_CODES_DEF = 512;
    localparam int MATRIX_ROWS   = 17;
    localparam int OUT_ROWS      = 16;
    localparam int OUT_IDX_W     = $clog2(OUT_ROWS);
    localparam int STICK_ENTRIES = 82;
    localparam int STICK_SKIP    = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_KEY_DOWN  = 3'd0,
        FUNC_KEY_UP    = 3'd1,
        FUNC_TICK      = 3'd2,
        FUNC_MAP_READ  = 3'd3,
        FUNC_MAP_WRITE = 3'd4
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINK_ONE   = 2'd0,
        REG_LINK_TWO   = 2'd1,
        REG_LINK_THREE = 2'd2
    } cfg_reg_t;

    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_MAP = 1'b1;

    typedef logic [BYTE_W-1:0] row_byte_t;

    localparam int ROW_SHIFT  = 2;
    localparam int ROW_LOCK   = 8;
    localparam int ROW_STICK  = 12;
    localparam int ROW_LINKS  = 13;
    localparam int ROW_OPTION = 14;
    localparam int ROW_TICK   = 15;

    localparam row_byte_t MASK_HIGH2  = 8'hC0;
    localparam row_byte_t MASK_LOCK   = 8'h40;
    localparam row_byte_t MASK_NOLINK = 8'h80;
    localparam row_byte_t MASK_SHIFT  = 8'h20;
    localparam row_byte_t MASK_LINK1  = 8'h40;
    localparam row_byte_t MASK_LINK3  = 8'h80;

    localparam logic [CODE_W-1:0] CODE_F2     = 9'd283;
    localparam logic [CODE_W-1:0] CODE_F4     = 9'd285;
    localparam logic [CODE_W-1:0] CODE_F6     = 9'd287;
    localparam logic [CODE_W-1:0] CODE_F8     = 9'd289;
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 9'd303;
    localparam logic [CODE_W-1:0] CODE_RSHIFT = 9'd304;

    // Each entry: source row, source mask, target row, target mask, high byte first.
    localparam logic [31:0] STICK_TAB [STICK_ENTRIES] = '{
        32'h07080C01, 32'h07800C02, 32'h08200C04, 32'h07200C08, 32'h07100C10, 32'h02200C20,
        32'h00010C01, 32'h00040C02, 32'h01010C04, 32'h00020C08, 32'h05800C10, 32'h0A200C20,
        32'h01400D01, 32'h0A400D02, 32'h01800D04, 32'h00400D08, 32'h00800D10, 32'h05800D20,
        32'h08200E01, 32'h07100E01, 32'h07200E01, 32'h06200E01, 32'h06100E01, 32'h05100E01,
        32'h05200E01,
        32'h08800E02, 32'h07800E02, 32'h07400E02, 32'h06800E02, 32'h06400E02, 32'h05400E02,
        32'h04400E02,
        32'h08080E04, 32'h07040E04, 32'h04040E04, 32'h03040E04, 32'h04100E04, 32'h03100E04,
        32'h04800E04, 32'h03400E04,
        32'h07080E08, 32'h06080E08, 32'h03080E08, 32'h02040E08, 32'h03200E08, 32'h02080E08,
        32'h03800E08, 32'h02400E08,
        32'h05800E10, 32'h02200E20,
        32'h05100F01, 32'h05200F01, 32'h04200F01, 32'h04100F01, 32'h03200F01, 32'h03100F01,
        32'h02080F01,
        32'h06400F02, 32'h05400F02, 32'h04400F02, 32'h04800F02, 32'h03800F02, 32'h03400F02,
        32'h02400F02,
        32'h08080F04, 32'h07040F04, 32'h04040F04, 32'h03040F04, 32'h08200F04, 32'h07200F04,
        32'h08800F04, 32'h07400F04,
        32'h07080F08, 32'h06080F08, 32'h03080F08, 32'h03040F08, 32'h07100F08, 32'h06200F08,
        32'h07800F08, 32'h06800F08,
        32'h05800F10, 32'h02200F20
    };

endpackage

### hdl/kmc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the key table of the keyboard matrix controller; defaults come from kmc_pkg.
module kmc_ram #(
    parameter int WIDTH = kmc_pkg::ENTRY_W,
    parameter int DEPTH = kmc_pkg::KEY_CODES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### hdl/keyboard_matrix_controller.sv
// Keyboard matrix controller: remappable key table, 17-row key matrix, scan output.
// Depends on kmc_pkg and kmc_ram.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   tuser func, tdata key_code, new_row, new_mask
//  m_*       out        m_tvalid / m_tready   tuser out_kind, tdata out_row, out_byte, tlast
//  cfg_*     in         cfg_wr_en             cfg_index, cfg_data
//
// An item is taken in every cycle that s_tready is high; it reads the key table on entry
// and is processed from the s1 registers in a single stage, where key events and map
// writes never wait. Results leave from an output buffer, one per cycle while m_tready
// is high: a scan tick gives 16, other ticks and map reads give one. Input stalls
// only while the key table clears after reset or an item with results meets a busy buffer.
module keyboard_matrix_controller #(
    parameter int KEY_CODES = kmc_pkg::KEY_CODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kmc_pkg::S_TDATA_W-1:0]       s_tdata,    // key_code, new_row, new_mask
    input  logic [kmc_pkg::FUNC_W-1:0]          s_tuser,    // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kmc_pkg::M_TDATA_W-1:0]       m_tdata,    // out_row, out_byte
    output logic                                m_tuser,    // out_kind
    output logic                                m_tlast,    // last
    input  logic                                cfg_wr_en,
    input  logic [kmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic                                cfg_data
);

    import kmc_pkg::*;

    localparam int AW = $clog2(KEY_CODES);

    logic [CODE_W-1:0]  in_code;
    logic [ROW_W-1:0]   in_row;
    logic [BYTE_W-1:0]  in_mask;
    logic               accept;
    logic [AW-1:0]      rd_addr;

    logic               s1_valid_reg;
    logic [FUNC_W-1:0]  s1_func_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [BYTE_W-1:0]  s1_mask_reg;
    logic               s1_in_range_reg;
    logic               fwd_valid_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic               clr_busy_reg;
    logic [AW-1:0]      clr_addr_reg;

    row_byte_t          mat_reg [MATRIX_ROWS];
    row_byte_t          mat_next [MATRIX_ROWS];
    logic               lock_reg, lock_next;
    logic               auto_reg, auto_next;
    logic               true_reg, true_next;
    logic               scan_reg, scan_next;
    logic [1:0]         tick_reg, tick_next;
    logic               link_one_reg, link_two_reg, link_three_reg;

    logic               em_busy_reg;
    logic [OUT_IDX_W-1:0] em_idx_reg;
    logic               em_kind_reg;
    logic [ROW_W-1:0]   em_rd_row_reg, em_rd_row_next;
    logic [BYTE_W-1:0]  em_rd_mask_reg, em_rd_mask_next;
    row_byte_t          em_buf_reg [OUT_ROWS];
    row_byte_t          em_buf_next [OUT_ROWS];
    logic               em_load;
    logic               em_load_kind;
    logic [OUT_IDX_W-1:0] em_load_idx;

    logic [ENTRY_W-1:0] ram_rd_data;
    logic [ENTRY_W-1:0] entry;
    logic [ROW_W-1:0]   ent_row;
    logic [BYTE_W-1:0]  ent_mask;
    logic               tbl_we;
    logic               ram_we;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;

    logic               needs_out;
    logic               m_done;
    logic               em_free;
    logic               s1_go;

    assign in_code = s_tdata[CODE_W-1:0];
    assign in_row  = s_tdata[CODE_W +: ROW_W];
    assign in_mask = s_tdata[CODE_W+ROW_W +: BYTE_W];
    assign rd_addr = AW'(in_code);

    assign needs_out = (s1_func_reg == FUNC_TICK) || (s1_func_reg == FUNC_MAP_READ);
    assign m_done    = m_tvalid && m_tready && m_tlast;
    assign em_free   = !em_busy_reg || m_done;
    assign s1_go     = s1_valid_reg && (!needs_out || em_free);
    assign s_tready  = !clr_busy_reg && (!s1_valid_reg || s1_go);
    assign accept    = s_tvalid && s_tready;

    assign entry    = !s1_in_range_reg ? '0 : (fwd_valid_reg ? fwd_data_reg : ram_rd_data);
    assign ent_row  = entry[ENTRY_W-1:BYTE_W];
    assign ent_mask = entry[BYTE_W-1:0];

    assign tbl_we      = s1_go && (s1_func_reg == FUNC_MAP_WRITE) && s1_in_range_reg;
    assign ram_we      = clr_busy_reg || tbl_we;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : AW'(s1_code_reg);
    assign ram_wr_data = clr_busy_reg ? '0 : {s1_row_reg, s1_mask_reg};

    kmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_CODES)
    ) u_key_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(KEY_CODES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg     <= s_tuser;
            s1_code_reg     <= in_code;
            s1_row_reg      <= in_row;
            s1_mask_reg     <= in_mask;
            s1_in_range_reg <= (32'(in_code) < KEY_CODES);
            fwd_valid_reg   <= tbl_we && (ram_wr_addr == rd_addr);
            fwd_data_reg    <= ram_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_one_reg   <= 1'b0;
            link_two_reg   <= 1'b0;
            link_three_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LINK_ONE:   link_one_reg   <= cfg_data;
                REG_LINK_TWO:   link_two_reg   <= cfg_data;
                REG_LINK_THREE: link_three_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic       down;
        logic [1:0] tk;
        logic       lk;
        logic [31:0] st;
        row_byte_t  r15;
        row_byte_t  der [4];

        mat_next        = mat_reg;
        lock_next       = lock_reg;
        auto_next       = auto_reg;
        true_next       = true_reg;
        scan_next       = scan_reg;
        tick_next       = tick_reg;
        em_buf_next     = em_buf_reg;
        em_rd_row_next  = em_rd_row_reg;
        em_rd_mask_next = em_rd_mask_reg;
        em_load         = 1'b0;
        em_load_kind    = KIND_ROW;
        em_load_idx     = OUT_IDX_W'(OUT_ROWS - 1);
        down            = (s1_func_reg == FUNC_KEY_DOWN);
        tk              = tick_reg + 2'd1;
        lk              = lock_reg;
        st              = '0;
        r15             = {tk[0], tk[1], mat_reg[ROW_TICK][5:0]};
        der[0]          = mat_reg[ROW_STICK] & MASK_HIGH2;
        der[1]          = '0;
        der[2]          = '0;
        der[3]          = r15 & MASK_HIGH2;

        if (s1_go)
        begin
            case (s1_func_reg)
                FUNC_KEY_DOWN, FUNC_KEY_UP:
                begin
                    if (s1_code_reg == CODE_F2 || s1_code_reg == CODE_F4 ||
                        s1_code_reg == CODE_F6 || s1_code_reg == CODE_F8)
                    begin
                        auto_next = down;
                    end
                    if (s1_code_reg == CODE_LSHIFT || s1_code_reg == CODE_RSHIFT)
                    begin
                        true_next = down;
                    end
                    for (int r = 0; r < MATRIX_ROWS; r++)
                    begin
                        if (ent_row == ROW_W'(r))
                        begin
                            mat_next[r] = down ? (mat_reg[r] | ent_mask)
                                               : (mat_reg[r] & ~ent_mask);
                        end
                    end
                    if (((mat_next[ROW_LOCK] & MASK_LOCK) != '0) &&
                        ((mat_reg[ROW_LOCK] & MASK_LOCK) == '0))
                    begin
                        lock_next = !lock_reg;
                    end
                    if (true_next || auto_next)
                    begin
                        mat_next[ROW_SHIFT] = mat_next[ROW_SHIFT] | MASK_SHIFT;
                    end
                    else
                    begin
                        mat_next[ROW_SHIFT] = mat_next[ROW_SHIFT] & ~MASK_SHIFT;
                    end
                    scan_next = 1'b1;
                end
                FUNC_TICK:
                begin
                    tick_next = tk;
                    em_load   = 1'b1;
                    if (!scan_reg)
                    begin
                        mat_next[ROW_TICK]    = r15;
                        em_buf_next[ROW_TICK] = r15;
                    end
                    else
                    begin
                        scan_next   = 1'b0;
                        em_load_idx = '0;
                        for (int n = 0; n < STICK_ENTRIES; n++)
                        begin
                            st = STICK_TAB[n];
                            if ((n >= STICK_SKIP || link_two_reg) &&
                                ((mat_reg[st[28:24]] & st[23:16]) != '0))
                            begin
                                der[st[9:8]] = der[st[9:8]] | st[7:0];
                            end
                        end
                        if (!link_two_reg && ((mat_reg[ROW_SHIFT] & MASK_SHIFT) != '0))
                        begin
                            lk = 1'b0;
                        end
                        lock_next = lk;
                        if (lk)
                        begin
                            der[ROW_LINKS-ROW_STICK] = der[ROW_LINKS-ROW_STICK] | MASK_LOCK;
                        end
                        if (!link_two_reg)
                        begin
                            der[ROW_LINKS-ROW_STICK] = der[ROW_LINKS-ROW_STICK] | MASK_NOLINK;
                        end
                        if (link_three_reg)
                        begin
                            der[ROW_OPTION-ROW_STICK] = der[ROW_OPTION-ROW_STICK] | MASK_LINK3;
                        end
                        if (link_one_reg)
                        begin
                            der[ROW_OPTION-ROW_STICK] = der[ROW_OPTION-ROW_STICK] | MASK_LINK1;
                        end
                        for (int k = 0; k < OUT_ROWS; k++)
                        begin
                            if (k < ROW_STICK)
                            begin
                                em_buf_next[k] = mat_reg[k];
                            end
                            else
                            begin
                                mat_next[k]    = der[k-ROW_STICK];
                                em_buf_next[k] = der[k-ROW_STICK];
                            end
                        end
                    end
                end
                FUNC_MAP_READ:
                begin
                    em_load         = 1'b1;
                    em_load_kind    = KIND_MAP;
                    em_rd_row_next  = ent_row;
                    em_rd_mask_next = ent_mask;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MATRIX_ROWS; r++)
            begin
                mat_reg[r] <= '0;
            end
            lock_reg <= 1'b0;
            auto_reg <= 1'b0;
            true_reg <= 1'b0;
            scan_reg <= 1'b0;
            tick_reg <= '0;
        end
        else
        begin
            mat_reg  <= mat_next;
            lock_reg <= lock_next;
            auto_reg <= auto_next;
            true_reg <= true_next;
            scan_reg <= scan_next;
            tick_reg <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_busy_reg <= 1'b0;
            em_idx_reg  <= '0;
            em_kind_reg <= KIND_ROW;
        end
        else if (em_load)
        begin
            em_busy_reg <= 1'b1;
            em_idx_reg  <= em_load_idx;
            em_kind_reg <= em_load_kind;
        end
        else if (m_tvalid && m_tready)
        begin
            if (m_tlast)
            begin
                em_busy_reg <= 1'b0;
            end
            else
            begin
                em_idx_reg <= em_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_load)
        begin
            em_buf_reg     <= em_buf_next;
            em_rd_row_reg  <= em_rd_row_next;
            em_rd_mask_reg <= em_rd_mask_next;
        end
    end

    assign m_tvalid = em_busy_reg;
    assign m_tlast  = &em_idx_reg;
    assign m_tuser  = em_kind_reg;
    assign m_tdata  = {(M_TDATA_W - ROW_W - BYTE_W)'(0),
                       (em_kind_reg == KIND_MAP) ? em_rd_mask_reg : em_buf_reg[em_idx_reg],
                       (em_kind_reg == KIND_MAP) ? em_rd_row_reg : ROW_W'(em_idx_reg)};

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy_reg |-> !s_tready)
        else $error("item accepted while the key table is being cleared");

    a_load_only_when_free: assert property (
        @(posedge clk) disable iff (!rst_n) em_load |-> (!em_busy_reg || m_done))
        else $error("output buffer reloaded while results are still pending");

    a_shift_bit_tracks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_func_reg == FUNC_KEY_DOWN || s1_func_reg == FUNC_KEY_UP))
        |=> (((mat_reg[ROW_SHIFT] & MASK_SHIFT) != '0) == (auto_reg || true_reg)))
        else $error("row 2 shift bit does not follow the held shift keys");

    a_no_output_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy_reg |-> !em_busy_reg)
        else $error("result pending during the key table clear");

endmodule

### tb/tb_keyboard_matrix_controller.sv
// Self-checking testbench for keyboard_matrix_controller: drives key, tick and map items
// on the input stream and checks every output item against an in-bench matrix predictor.
// Depends on kmc_pkg and the keyboard_matrix_controller RTL.
module tb_keyboard_matrix_controller;
    import kmc_pkg::*;

    localparam int TBL_DEPTH   = 512;
    localparam int MX_ROWS     = 17;
    localparam int SCAN_ROWS   = 16;
    localparam int JOY_N       = 82;
    localparam int JOY_NOLINK  = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_CYCLES = 20;
    localparam int LIMIT       = 400000;

    localparam int SHIFT_ROW = 2;
    localparam int LOCK_ROW  = 8;
    localparam logic [7:0] LOCK_BIT  = 8'h40;
    localparam logic [7:0] SHIFT_BIT = 8'h20;

    localparam logic [8:0] KEY_F2 = 9'd283;
    localparam logic [8:0] KEY_F4 = 9'd285;
    localparam logic [8:0] KEY_F6 = 9'd287;
    localparam logic [8:0] KEY_F8 = 9'd289;
    localparam logic [8:0] KEY_LSHIFT = 9'd303;
    localparam logic [8:0] KEY_RSHIFT = 9'd304;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    // Source row, source mask, target row, target mask, high byte first.
    localparam logic [31:0] JOY_MAP [JOY_N] = '{
        32'h07080C01, 32'h07800C02, 32'h08200C04, 32'h07200C08, 32'h07100C10, 32'h02200C20,
        32'h00010C01, 32'h00040C02, 32'h01010C04, 32'h00020C08, 32'h05800C10, 32'h0A200C20,
        32'h01400D01, 32'h0A400D02, 32'h01800D04, 32'h00400D08, 32'h00800D10, 32'h05800D20,
        32'h08200E01, 32'h07100E01, 32'h07200E01, 32'h06200E01, 32'h06100E01, 32'h05100E01,
        32'h05200E01, 32'h08800E02, 32'h07800E02, 32'h07400E02, 32'h06800E02, 32'h06400E02,
        32'h05400E02, 32'h04400E02, 32'h08080E04, 32'h07040E04, 32'h04040E04, 32'h03040E04,
        32'h04100E04, 32'h03100E04, 32'h04800E04, 32'h03400E04, 32'h07080E08, 32'h06080E08,
        32'h03080E08, 32'h02040E08, 32'h03200E08, 32'h02080E08, 32'h03800E08, 32'h02400E08,
        32'h05800E10, 32'h02200E20, 32'h05100F01, 32'h05200F01, 32'h04200F01, 32'h04100F01,
        32'h03200F01, 32'h03100F01, 32'h02080F01, 32'h06400F02, 32'h05400F02, 32'h04400F02,
        32'h04800F02, 32'h03800F02, 32'h03400F02, 32'h02400F02, 32'h08080F04, 32'h07040F04,
        32'h04040F04, 32'h03040F04, 32'h08200F04, 32'h07200F04, 32'h08800F04, 32'h07400F04,
        32'h07080F08, 32'h06080F08, 32'h03080F08, 32'h03040F08, 32'h07100F08, 32'h06200F08,
        32'h07800F08, 32'h06800F08, 32'h05800F10, 32'h02200F20
    };

    localparam logic [8:0] HOT_CODES [16] = '{
        9'd283, 9'd285, 9'd287, 9'd289, 9'd303, 9'd304, 9'd0, 9'd1,
        9'd64, 9'd100, 9'd200, 9'd255, 9'd256, 9'd300, 9'd400, 9'd511
    };

    typedef struct packed {
        logic       kind;
        logic [4:0] row;
        logic [7:0] data;
        logic       last;
    } row_report_t;

    typedef struct packed {
        logic [2:0] fn;
        logic [8:0] code;
        logic [4:0] nrow;
        logic [7:0] nmask;
        logic       chk;
        logic       ekind;
        logic [4:0] erow;
        logic [7:0] edata;
    } dir_row_t;

    localparam int DIR_N = 25;

    dir_row_t dir_tab [DIR_N] = '{
        '{FUNC_MAP_READ,  9'd0,   5'd0,  8'h00, 1'b1, KIND_MAP, 5'd0,  8'h00},
        '{FUNC_TICK,      9'd0,   5'd0,  8'h00, 1'b1, KIND_ROW, 5'd15, 8'h80},
        '{FUNC_MAP_WRITE, 9'd511, 5'd31, 8'hFF, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_READ,  9'd511, 5'd0,  8'h00, 1'b1, KIND_MAP, 5'd31, 8'hFF},
        '{FUNC_MAP_WRITE, 9'd0,   5'd16, 8'hFF, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_WRITE, 9'd100, 5'd8,  8'h40, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_WRITE, 9'd101, 5'd7,  8'h88, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_WRITE, 9'd102, 5'd0,  8'h07, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_WRITE, 9'd283, 5'd5,  8'h80, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_WRITE, 9'd303, 5'd1,  8'hC1, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd511, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd0,   5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd100, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd283, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd101, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_TICK,      9'd0,   5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_UP,    9'd283, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd304, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_UP,    9'd100, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_KEY_DOWN,  9'd100, 5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_SPARE_LO,  9'd511, 5'd31, 8'hFF, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_SPARE_HI,  9'd303, 5'd8,  8'h40, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_TICK,      9'd0,   5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_TICK,      9'd0,   5'd0,  8'h00, 1'b0, KIND_ROW, 5'd0,  8'h00},
        '{FUNC_MAP_READ,  9'd303, 5'd0,  8'h00, 1'b1, KIND_MAP, 5'd1,  8'hC1}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;

    logic [12:0] kt_entry [TBL_DEPTH];
    logic [7:0]  mx_row [MX_ROWS];
    logic        lock_on, auto_held, true_held, scan_due;
    logic [1:0]  ticker;
    logic        lnk1, lnk2, lnk3;

    row_report_t row_reports_due [$];

    int errors = 0;
    int reports_checked = 0;
    int items_done = 0;
    int scans_done = 0;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asked = 0;
    int hold_seen;
    int hold_left;

    keyboard_matrix_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void kbd_key(input logic [8:0] code, input logic down);
        logic [7:0] prev_lock;
        logic [4:0] r;
        logic [7:0] m;
        prev_lock = mx_row[LOCK_ROW] & LOCK_BIT;
        r = kt_entry[code][12:8];
        m = kt_entry[code][7:0];
        if (code == KEY_F2 || code == KEY_F4 || code == KEY_F6 || code == KEY_F8)
            auto_held = down;
        if (code == KEY_LSHIFT || code == KEY_RSHIFT)
            true_held = down;
        if (r < MX_ROWS)
            mx_row[r] = down ? (mx_row[r] | m) : (mx_row[r] & ~m);
        scan_due = 1'b1;
        if ((mx_row[LOCK_ROW] & LOCK_BIT) != 0 && prev_lock == 0)
            lock_on = !lock_on;
        if (true_held || auto_held)
            mx_row[SHIFT_ROW] = mx_row[SHIFT_ROW] | SHIFT_BIT;
        else
            mx_row[SHIFT_ROW] = mx_row[SHIFT_ROW] & ~SHIFT_BIT;
    endfunction

    function automatic void kbd_scan();
        logic [31:0] w;
        int first;
        first = lnk2 ? 0 : JOY_NOLINK;
        mx_row[12] = mx_row[12] & 8'hC0;
        mx_row[13] = 8'h00;
        mx_row[14] = 8'h00;
        mx_row[15] = mx_row[15] & 8'hC0;
        for (int n = first; n < JOY_N; n++)
        begin
            w = JOY_MAP[n];
            if ((mx_row[w[31:24]] & w[23:16]) != 0)
                mx_row[w[15:8]] = mx_row[w[15:8]] | w[7:0];
        end
        if (!lnk2 && (mx_row[SHIFT_ROW] & SHIFT_BIT) != 0)
            lock_on = 1'b0;
        if (lock_on)
            mx_row[13] = mx_row[13] | 8'h40;
        if (!lnk2)
            mx_row[13] = mx_row[13] | 8'h80;
        if (lnk3)
            mx_row[14] = mx_row[14] | 8'h80;
        if (lnk1)
            mx_row[14] = mx_row[14] | 8'h40;
    endfunction

    function automatic void kbd_step(input logic [2:0] fn, input logic [8:0] code,
                                     input logic [4:0] nrow, input logic [7:0] nmask);
        row_report_t rep;
        case (fn)
            FUNC_KEY_DOWN: kbd_key(code, 1'b1);
            FUNC_KEY_UP:   kbd_key(code, 1'b0);
            FUNC_TICK:
            begin
                ticker = ticker + 2'd1;
                mx_row[15] = {ticker[0], ticker[1], mx_row[15][5:0]};
                if (!scan_due)
                begin
                    rep = '{kind: KIND_ROW, row: 5'd15, data: mx_row[15], last: 1'b1};
                    row_reports_due.push_back(rep);
                end
                else
                begin
                    scan_due = 1'b0;
                    kbd_scan();
                    scans_done++;
                    for (int k = 0; k < SCAN_ROWS; k++)
                    begin
                        rep = '{kind: KIND_ROW, row: k[4:0], data: mx_row[k],
                                last: (k == SCAN_ROWS - 1)};
                        row_reports_due.push_back(rep);
                    end
                end
            end
            FUNC_MAP_READ:
            begin
                rep = '{kind: KIND_MAP, row: kt_entry[code][12:8],
                        data: kt_entry[code][7:0], last: 1'b1};
                row_reports_due.push_back(rep);
            end
            FUNC_MAP_WRITE: kt_entry[code] = {nrow, nmask};
            default: ;
        endcase
    endfunction

    function automatic logic [8:0] pick_code();
        if ($urandom_range(0, 3) != 0)
            return HOT_CODES[$urandom_range(0, 15)];
        return $urandom_range(0, TBL_DEPTH - 1);
    endfunction

    task automatic send_item(input logic [2:0] fn, input logic [8:0] code,
                             input logic [4:0] nrow, input logic [7:0] nmask);
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {2'b00, nmask, nrow, code};
        do
            @(posedge clk);
        while (!s_tready);
        kbd_step(fn, code, nrow, nmask);
        if (fn <= FUNC_MAP_WRITE)
            items_done++;
    endtask

    task automatic tx_gap();
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic random_item();
        int sel;
        logic [4:0] r;
        logic [7:0] m;
        sel = $urandom_range(0, 99);
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
        m = $urandom_range(0, 1) ? (8'h01 << $urandom_range(0, 7)) : $urandom_range(0, 255);
        if (sel < 14)
            send_item(FUNC_MAP_WRITE, pick_code(), r, m);
        else if (sel < 48)
            send_item(FUNC_KEY_DOWN, pick_code(), r, m);
        else if (sel < 68)
            send_item(FUNC_KEY_UP, pick_code(), r, m);
        else if (sel < 86)
            send_item(FUNC_TICK, $urandom_range(0, 511), r, m);
        else if (sel < 96)
            send_item(FUNC_MAP_READ, pick_code(), r, m);
        else
            send_item($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI), pick_code(), r, m);
    endtask

    task automatic run_phase(input int n_items);
        int start;
        start = items_done;
        while (items_done - start < n_items)
        begin
            tx_gap();
            random_item();
        end
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (row_reports_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_links(input logic l1, input logic l2, input logic l3);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LINK_ONE;
        cfg_data  <= l1;
        @(posedge clk);
        lnk1 = l1;
        cfg_index <= REG_LINK_TWO;
        cfg_data  <= l2;
        @(posedge clk);
        lnk2 = l2;
        cfg_index <= REG_LINK_THREE;
        cfg_data  <= l3;
        @(posedge clk);
        lnk3 = l3;
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        row_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (row_reports_due.size() == 0)
            begin
                $error("unexpected result item: row %0d data 0x%02h", m_tdata[4:0],
                       m_tdata[12:5]);
                errors++;
            end
            else
            begin
                want = row_reports_due.pop_front();
                reports_checked++;
                if (m_tuser !== want.kind)
                begin
                    $error("out_kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[4:0] !== want.row)
                begin
                    $error("out_row mismatch: expected %0d, actual %0d", want.row,
                           m_tdata[4:0]);
                    errors++;
                end
                if (m_tdata[12:5] !== want.data)
                begin
                    $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.data,
                           m_tdata[12:5]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb_keyboard_matrix_controller: FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_row_t d;
        row_report_t typed;
        for (int i = 0; i < TBL_DEPTH; i++)
            kt_entry[i] = '0;
        for (int i = 0; i < MX_ROWS; i++)
            mx_row[i] = '0;
        lock_on = 1'b0;
        auto_held = 1'b0;
        true_held = 1'b0;
        scan_due = 1'b0;
        ticker = 2'd0;
        lnk1 = 1'b0;
        lnk2 = 1'b0;
        lnk3 = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        rx_idle_pct <= 20;
        set_links(1'b0, 1'b0, 1'b0);

        for (int i = 0; i < DIR_N; i++)
        begin
            d = dir_tab[i];
            send_item(d.fn, d.code, d.nrow, d.nmask);
            if (d.chk)
            begin
                typed = '{kind: d.ekind, row: d.erow, data: d.edata, last: 1'b1};
                void'(row_reports_due.pop_back());
                row_reports_due.push_back(typed);
            end
        end
        wait_quiet();

        set_links(1'b1, 1'b1, 1'b1);
        tx_idle_pct = 20;
        rx_idle_pct <= 54;
        run_phase(60);
        wait_quiet();

        set_links(1'b0, 1'b1, 1'b1);
        tx_idle_pct = 54;
        rx_idle_pct <= 20;
        run_phase(60);
        wait_quiet();

        // The output side stalls for a long stretch while scan ticks keep coming.
        set_links(1'b1, 1'b0, 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_asked <= hold_asked + 1;
        repeat (12)
        begin
            send_item(FUNC_KEY_DOWN, pick_code(), 5'd0, 8'h00);
            send_item(FUNC_TICK, 9'd0, 5'd0, 8'h00);
        end
        run_phase(36);
        wait_quiet();

        set_links(1'b0, 1'b1, 1'b0);
        run_phase(60);
        wait_quiet();

        $display("Summary: %0d items accepted, %0d result items checked, %0d full scans.",
                 items_done, reports_checked, scans_done);
        $display("Summary: link settings 000, 111, 011, 100, 010; varied idling; long stall.");
        if (errors == 0)
            $display("tb_keyboard_matrix_controller: PASS");
        else
            $display("tb_keyboard_matrix_controller: FAIL");
        $finish;
    end

endmodule
